// ----- rtl/icf_pkg.sv -----
`default_nettype none

package icf_pkg;

   // Timer and register widths
   localparam int TIMER_BITS_DEF = 10;
   localparam int TICK_W         = 10;
   localparam int CSR_INDEX_W    = 2;

   // Register reset values
   localparam logic [1:0]        DRIVER_MODE_RST  = 2'd0;
   localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = TICK_W'(200);
   localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = TICK_W'(700);
   localparam logic [TICK_W-1:0] POWER_TICKS_RST  = TICK_W'(5);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVER_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_TICKS  = 2'd3;

   // Driver wiring modes
   localparam logic [1:0] MODE_A = 2'd0;
   localparam logic [1:0] MODE_B = 2'd1;
   localparam logic [1:0] MODE_C = 2'd2;
   localparam logic [1:0] MODE_D = 2'd3;

   // Operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_CMD  = 2'd1;
   localparam logic [1:0] OP_INIT = 2'd2;

   // Reported filter states
   localparam logic [1:0] FS_UNKNOWN      = 2'd0;
   localparam logic [1:0] FS_PASS_IR      = 2'd1;
   localparam logic [1:0] FS_BLOCK_IR     = 2'd2;
   localparam logic [1:0] FS_NOT_READABLE = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_HOLD,
      PH_POWER
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       pass_ir;
      logic       block_ir;
   } req_type;

   typedef struct packed {
      logic       pin_zero;
      logic       pin_one;
      logic       pin_two;
      logic [1:0] filter_state;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        driver_mode;
      logic [TICK_W-1:0] settle_ticks;
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] power_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      cnt_zero;
   } core_status_type;

endpackage

`default_nettype wire

// ----- rtl/icf_req_if.sv -----
`default_nettype none

interface icf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic       pass_ir;
   logic       block_ir;

   modport source (output valid, output operation, output pass_ir, output block_ir,
                   input ready);
   modport sink   (input valid, input operation, input pass_ir, input block_ir,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/icf_rsp_if.sv -----
`default_nettype none

interface icf_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_zero;
   logic       pin_one;
   logic       pin_two;
   logic [1:0] filter_state;
   logic       busy_res;
   logic       rejected;

   modport source (output valid, output pin_zero, output pin_one, output pin_two,
                   output filter_state, output busy_res, output rejected,
                   input ready);
   modport sink   (input valid, input pin_zero, input pin_one, input pin_two,
                   input filter_state, input busy_res, input rejected,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/icf_csr_if.sv -----
`default_nettype none

interface icf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/ir_cut_filter_sequencer.sv -----
// IR-cut filter pin sequencer.
// Input channel req_ch carries one word per event: a millisecond tick, a
// filter command (pass_ir wins over block_ir) or an init request. Every
// accepted word yields exactly one word on rsp_ch with the pin levels after
// that event, the filter state read back from them, busy and rejected flags.
// The csr_ch port writes driver mode and the settle, hold and power-off
// waits; it is always ready. The user must see that it is written only
// while no word is in flight; the block does not enforce this. An accepted
// word moves from the input register into the result register, which
// drives rsp_ch.valid. One word per cycle is sustained while rsp_ch is
// ready; the pin state and countdown register update as each word moves on.
// A stalled receiver holds the result word; one more word is taken into the
// input register, after which req_ch.ready drops until rsp_ch drains.
// Synchronous reset clears all pins low, stops any sequence, zeroes the
// countdown and reloads the registers with their defaults.
`default_nettype none

module ir_cut_filter_sequencer
   import icf_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   icf_req_if.sink      req_ch,
   icf_rsp_if.source    rsp_ch,
   icf_csr_if.sink      csr_ch
);

   cfg_type         cfg;
   core_status_type status;
   req_type         in_ff;
   logic            in_vld_ff;
   rsp_type         rsp_ff;
   rsp_type         result;
   logic            rsp_vld_ff;
   logic            adv;
   logic            take;

   icf_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   icf_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result),
      .status (status)
   );

   // Handshake between the two register stages
   assign adv          = in_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || adv;
   assign take         = req_ch.valid && req_ch.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.operation <= req_ch.operation;
         in_ff.pass_ir   <= req_ch.pass_ir;
         in_ff.block_ir  <= req_ch.block_ir;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= result;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.pin_zero     = rsp_ff.pin_zero;
   assign rsp_ch.pin_one      = rsp_ff.pin_one;
   assign rsp_ch.pin_two      = rsp_ff.pin_two;
   assign rsp_ch.filter_state = rsp_ff.filter_state;
   assign rsp_ch.busy_res     = rsp_ff.busy_res;
   assign rsp_ch.rejected     = rsp_ff.rejected;

`ifndef NO_ASSERTIONS
   // A running sequence never sits on an expired countdown
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      status.phase != PH_IDLE |-> !status.cnt_zero)
      else $error("sequence active with expired countdown");

   // A rejected command only happens while a sequence runs
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.rejected |-> rsp_ff.busy_res)
      else $error("rejected word reported while idle");

   // A held input word is not dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff)
      else $error("input word lost while stalled");

   // A result word only appears after the input stage advanced
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(adv))
      else $error("result word without a source word");
`endif

endmodule

`default_nettype wire

// ----- rtl/icf_csr_regs.sv -----
`default_nettype none

module icf_csr_regs
   import icf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   icf_csr_if.sink csr_ch,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;
   assign cfg          = cfg_ff;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.driver_mode  <= DRIVER_MODE_RST;
         cfg_ff.settle_ticks <= SETTLE_TICKS_RST;
         cfg_ff.hold_ticks   <= HOLD_TICKS_RST;
         cfg_ff.power_ticks  <= POWER_TICKS_RST;
      end else if (wr_en) begin
         unique case (csr_ch.index)
            CSR_DRIVER_MODE:  cfg_ff.driver_mode  <= csr_ch.wdata[1:0];
            CSR_SETTLE_TICKS: cfg_ff.settle_ticks <= csr_ch.wdata;
            CSR_HOLD_TICKS:   cfg_ff.hold_ticks   <= csr_ch.wdata;
            CSR_POWER_TICKS:  cfg_ff.power_ticks  <= csr_ch.wdata;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/icf_core.sv -----
`default_nettype none

module icf_core
   import icf_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  req_type         item,
   input  cfg_type         cfg,
   output rsp_type         result,
   output core_status_type status
);

   localparam int SW = TIMER_BITS + TICK_W;
   localparam logic [SW-1:0] LIM = SW'((1 << TIMER_BITS) - 1);

   // Clamp a programmed wait to the countdown width
   function automatic logic [TIMER_BITS-1:0] load_wait(input logic [TICK_W-1:0] w);
      logic [SW-1:0] ext;
      ext = SW'(w);
      if (ext > LIM) return TIMER_BITS'(LIM);
      return TIMER_BITS'(ext);
   endfunction

   logic [2:0]            pins_ff, pins_in;
   phase_type             phase_ff, phase_in;
   logic                  tgt_ff, tgt_in;
   logic [TIMER_BITS-1:0] cnt_ff, cnt_in;
   logic                  rej;
   logic                  go;
   logic                  mode_ab;
   logic [1:0]            fstate;

   assign mode_ab = (cfg.driver_mode == MODE_A) || (cfg.driver_mode == MODE_B);

   // Sequencer state, committed when the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff  <= '0;
         phase_ff <= PH_IDLE;
         tgt_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (adv) begin
         pins_ff  <= pins_in;
         phase_ff <= phase_in;
         tgt_ff   <= tgt_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state for one word
   always_comb begin
      pins_in  = pins_ff;
      phase_in = phase_ff;
      tgt_in   = tgt_ff;
      cnt_in   = cnt_ff;
      rej      = 1'b0;
      go       = 1'b0;

      unique case (item.operation)
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
               go = 1'b1;
            end
         end
         OP_CMD: begin
            if ((phase_ff == PH_SETTLE) || (phase_ff == PH_HOLD)) begin
               rej = 1'b1;
            end else if (mode_ab) begin
               // only a real change of position starts a sequence
               if ((item.pass_ir || item.block_ir) && (pins_ff[0] != item.pass_ir)) begin
                  pins_in[1] = 1'b0;
                  tgt_in     = item.pass_ir;
                  phase_in   = PH_SETTLE;
                  cnt_in     = load_wait(cfg.settle_ticks);
                  go         = 1'b1;
               end
            end else begin
               if (cfg.driver_mode == MODE_C) begin
                  pins_in[2] = 1'b0;
                  if (item.pass_ir) pins_in[1:0] = 2'b01;
                  else if (item.block_ir) pins_in[1:0] = 2'b10;
               end else begin
                  if (item.pass_ir) pins_in[0] = 1'b1;
                  else if (item.block_ir) pins_in[1] = 1'b1;
               end
               phase_in = PH_POWER;
               cnt_in   = load_wait(cfg.power_ticks);
               go       = 1'b1;
            end
         end
         OP_INIT: begin
            if (cfg.driver_mode == MODE_B) pins_in[1] = 1'b0;
            else if (cfg.driver_mode == MODE_C) pins_in[2] = 1'b1;
            else if (cfg.driver_mode == MODE_D) pins_in[1:0] = 2'b00;
         end
         default: ;
      endcase

      // Expired waits run on at once; settle then hold is the longest chain
      if (go) begin
         for (int i = 0; i < 2; i++) begin
            if ((phase_in != PH_IDLE) && (cnt_in == '0)) begin
               unique case (phase_in)
                  PH_IDLE: ;
                  PH_SETTLE: begin
                     pins_in[0] = tgt_in;
                     phase_in   = PH_HOLD;
                     cnt_in     = load_wait(cfg.hold_ticks);
                  end
                  PH_HOLD: begin
                     pins_in[1] = 1'b1;
                     phase_in   = PH_IDLE;
                  end
                  PH_POWER: begin
                     if (cfg.driver_mode == MODE_D) pins_in[1:0] = 2'b00;
                     else pins_in[2] = 1'b1;
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   // Filter position as read back from the pins
   always_comb begin
      if (mode_ab) begin
         fstate = pins_in[0] ? FS_PASS_IR : FS_BLOCK_IR;
      end else if (cfg.driver_mode == MODE_C) begin
         if (pins_in[0] && !pins_in[1]) fstate = FS_PASS_IR;
         else if (!pins_in[0] && pins_in[1]) fstate = FS_BLOCK_IR;
         else fstate = FS_UNKNOWN;
      end else begin
         fstate = FS_NOT_READABLE;
      end
   end

   assign result.pin_zero     = pins_in[0];
   assign result.pin_one      = pins_in[1];
   assign result.pin_two      = pins_in[2];
   assign result.filter_state = fstate;
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.rejected     = rej;

   assign status.phase    = phase_ff;
   assign status.cnt_zero = (cnt_ff == '0);

endmodule

`default_nettype wire

// ----- verif/ir_cut_filter_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, pin-report and register channels, keeps its own copy of
// the filter sequencer state and compares every pin report with its prediction.
module ir_cut_filter_checker
   import icf_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   icf_req_if   req_ch,
   icf_rsp_if   rsp_ch,
   icf_csr_if   csr_ch,
   output int   mismatch_count,
   output int   pending_count
);

   localparam int REPORT_LIMIT = 10;

   // register copies
   logic [1:0]        mode_q;
   logic [TICK_W-1:0] settle_q;
   logic [TICK_W-1:0] hold_q;
   logic [TICK_W-1:0] power_q;

   // sequencer copy: bit0 position/coil A, bit1 enable/coil B, bit2 power
   logic [2:0]        pins_q;
   phase_type         seq_phase;
   logic              target_q;
   int unsigned       countdown;

   rsp_type           expected_pins_q[$];
   int                failures;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      failures       = 0;
   end

   // waits saturate to the timer width
   function automatic int unsigned clamp_wait(logic [TICK_W-1:0] w);
      int unsigned lim;
      lim = (32'd1 << TIMER_BITS) - 32'd1;
      return (w > lim) ? lim : w;
   endfunction

   // run every step whose wait has already expired
   function automatic void finish_waits();
      for (int k = 0; k < 3; k++) begin
         if (seq_phase != PH_IDLE && countdown == 0) begin
            case (seq_phase)
               PH_SETTLE: begin
                  pins_q[0] = target_q;
                  seq_phase = PH_HOLD;
                  countdown = clamp_wait(hold_q);
               end
               PH_HOLD: begin
                  pins_q[1] = 1'b1;
                  seq_phase = PH_IDLE;
               end
               default: begin
                  // power-off follows the mode in force now
                  if (mode_q == MODE_D)
                     pins_q[1:0] = 2'b00;
                  else
                     pins_q[2] = 1'b1;
                  seq_phase = PH_IDLE;
               end
            endcase
         end
      end
   endfunction

   // apply one word to the state copy and return the pin report it causes
   function automatic rsp_type predict_pins(logic [1:0] op, logic pass, logic block);
      rsp_type r;
      logic    want;
      r = '0;
      case (op)
         OP_TICK: begin
            if (seq_phase != PH_IDLE) begin
               if (countdown > 0)
                  countdown--;
               finish_waits();
            end
         end
         OP_CMD: begin
            if (seq_phase == PH_SETTLE || seq_phase == PH_HOLD) begin
               r.rejected = 1'b1;
            end else if (mode_q == MODE_A || mode_q == MODE_B) begin
               if (pass || block) begin
                  want = pass;
                  if (pins_q[0] != want) begin
                     pins_q[1] = 1'b0;
                     target_q  = want;
                     seq_phase = PH_SETTLE;
                     countdown = clamp_wait(settle_q);
                     finish_waits();
                  end
               end
            end else begin
               if (mode_q == MODE_C) begin
                  pins_q[2] = 1'b0;
                  if (pass)
                     pins_q[1:0] = 2'b01;
                  else if (block)
                     pins_q[1:0] = 2'b10;
               end else begin
                  if (pass)
                     pins_q[0] = 1'b1;
                  else if (block)
                     pins_q[1] = 1'b1;
               end
               // a new command restarts the power-off countdown
               seq_phase = PH_POWER;
               countdown = clamp_wait(power_q);
               finish_waits();
            end
         end
         OP_INIT: begin
            case (mode_q)
               MODE_B: pins_q[1] = 1'b0;
               MODE_C: pins_q[2] = 1'b1;
               MODE_D: pins_q[1:0] = 2'b00;
               default: ;
            endcase
         end
         default: ;
      endcase

      r.pin_zero = pins_q[0];
      r.pin_one  = pins_q[1];
      r.pin_two  = pins_q[2];
      if (mode_q == MODE_A || mode_q == MODE_B)
         r.filter_state = pins_q[0] ? FS_PASS_IR : FS_BLOCK_IR;
      else if (mode_q == MODE_C)
         r.filter_state = (pins_q[1:0] == 2'b01) ? FS_PASS_IR :
                          (pins_q[1:0] == 2'b10) ? FS_BLOCK_IR : FS_UNKNOWN;
      else
         r.filter_state = FS_NOT_READABLE;
      r.busy_res = (seq_phase != PH_IDLE);
      return r;
   endfunction

   // sample all channels at the clock edge
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         mode_q    = DRIVER_MODE_RST;
         settle_q  = SETTLE_TICKS_RST;
         hold_q    = HOLD_TICKS_RST;
         power_q   = POWER_TICKS_RST;
         pins_q    = 3'b000;
         seq_phase = PH_IDLE;
         target_q  = 1'b0;
         countdown = 0;
         expected_pins_q.delete();
      end else begin
         // register writes
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_DRIVER_MODE:  mode_q   = csr_ch.wdata[1:0];
               CSR_SETTLE_TICKS: settle_q = csr_ch.wdata;
               CSR_HOLD_TICKS:   hold_q   = csr_ch.wdata;
               CSR_POWER_TICKS:  power_q  = csr_ch.wdata;
               default: ;
            endcase
         end

         // pin reports against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pin_zero     = rsp_ch.pin_zero;
            got.pin_one      = rsp_ch.pin_one;
            got.pin_two      = rsp_ch.pin_two;
            got.filter_state = rsp_ch.filter_state;
            got.busy_res     = rsp_ch.busy_res;
            got.rejected     = rsp_ch.rejected;
            if (expected_pins_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: pin report with none expected: p0=%b p1=%b p2=%b st=%0d busy=%b rej=%b",
                           $time, got.pin_zero, got.pin_one, got.pin_two,
                           got.filter_state, got.busy_res, got.rejected);
            end else begin
               want = expected_pins_q.pop_front();
               if (got.pin_zero !== want.pin_zero || got.pin_one !== want.pin_one ||
                   got.pin_two !== want.pin_two || got.filter_state !== want.filter_state ||
                   got.busy_res !== want.busy_res || got.rejected !== want.rejected) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: pin report mismatch: exp p0=%b p1=%b p2=%b st=%0d busy=%b rej=%b, got p0=%b p1=%b p2=%b st=%0d busy=%b rej=%b",
                              $time, want.pin_zero, want.pin_one, want.pin_two,
                              want.filter_state, want.busy_res, want.rejected,
                              got.pin_zero, got.pin_one, got.pin_two,
                              got.filter_state, got.busy_res, got.rejected);
               end
            end
         end

         // each accepted word yields one report
         if (req_ch.valid && req_ch.ready)
            expected_pins_q.push_back(predict_pins(req_ch.operation, req_ch.pass_ir,
                                                   req_ch.block_ir));
      end
      pending_count  <= expected_pins_q.size();
      mismatch_count <= failures;
   end

endmodule

// ----- verif/tb_ir_cut_filter_sequencer.sv -----
`timescale 1ns / 1ps

module tb_ir_cut_filter_sequencer;
   import icf_pkg::*;

   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [9:0]  WAIT_MAX     = 10'd1023;
   localparam int          LONG_TICKS   = 64;
   localparam int          RANDOM_WORDS = 1050;
   localparam int          PHASES       = 8;
   localparam int          LONG_HOLD    = 120;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          DRAIN_TAIL   = 8;

   logic clock;
   logic reset;
   bit   gaps_on;
   bit   long_stall;
   int   mismatches;
   int   pending;

   icf_req_if req_ch ();
   icf_rsp_if rsp_ch ();
   icf_csr_if csr_ch ();

   ir_cut_filter_sequencer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ir_cut_filter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // report receiver: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      rsp_ch.ready <= 1'b1;
      forever begin
         if (long_stall) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_stall = 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // give up when no channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // offer one command word, with an optional idle burst first
   task automatic send_word(input logic [1:0] op, input logic pass, input logic block);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.pass_ir   <= pass;
      req_ch.block_ir  <= block;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // mostly ticks so that sequences run to completion
   task automatic send_random_word();
      int          pick;
      logic [1:0]  op;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         op = OP_TICK;
      else if (pick < 85)
         op = OP_CMD;
      else if (pick < 95)
         op = OP_INIT;
      else
         op = OP_UNUSED;
      send_word(op, ($urandom_range(0, 9) < 4), ($urandom_range(0, 1) == 1));
   endtask

   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [9:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // all four registers, written once the report channel has drained
   task automatic program_regs(input logic [1:0] mode, input logic [9:0] settle,
                               input logic [9:0] hold, input logic [9:0] power);
      wait_all_results();
      csr_write(CSR_DRIVER_MODE, {8'd0, mode});
      csr_write(CSR_SETTLE_TICKS, settle);
      csr_write(CSR_HOLD_TICKS, hold);
      csr_write(CSR_POWER_TICKS, power);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [1:0] phase_modes [PHASES];
      int         n;
      phase_modes = '{MODE_A, MODE_C, MODE_B, MODE_D, MODE_C, MODE_A, MODE_D, MODE_B};
      gaps_on    = 1'b1;
      long_stall = 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_TICK;
      req_ch.pass_ir   <= 1'b0;
      req_ch.block_ir  <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_DRIVER_MODE;
      csr_ch.wdata     <= '0;
      do @(posedge clock); while (reset);

      // reset settings: init, idle tick, commands that change nothing, unused op
      send_word(OP_INIT, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_CMD, 1'b0, 1'b1);
      send_word(OP_CMD, 1'b0, 1'b0);
      send_word(OP_UNUSED, 1'b1, 1'b1);

      // zero waits finish in the same word; pass wins over block
      program_regs(MODE_A, 10'd0, 10'd0, 10'd5);
      send_word(OP_CMD, 1'b1, 1'b0);
      send_word(OP_CMD, 1'b1, 1'b1);
      send_word(OP_CMD, 1'b0, 1'b1);

      // short mode A sequence with a rejected command and init inside it
      program_regs(MODE_A, 10'd1, 10'd2, 10'd5);
      send_word(OP_CMD, 1'b1, 1'b0);
      send_word(OP_CMD, 1'b0, 1'b1);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_INIT, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);

      // mode B init drops enable
      program_regs(MODE_B, 10'd0, 10'd1, 10'd5);
      send_word(OP_INIT, 1'b0, 1'b0);
      send_word(OP_CMD, 1'b0, 1'b1);
      send_word(OP_TICK, 1'b0, 1'b0);

      // mode C: zero power time, command without request, countdown restart
      program_regs(MODE_C, 10'd0, 10'd0, 10'd0);
      send_word(OP_CMD, 1'b1, 1'b0);
      send_word(OP_CMD, 1'b0, 1'b0);
      program_regs(MODE_C, 10'd0, 10'd0, 10'd2);
      send_word(OP_CMD, 1'b0, 1'b1);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_CMD, 1'b1, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);

      // mode D pulse, then a mode C countdown that ends under mode D
      program_regs(MODE_D, 10'd0, 10'd0, 10'd1);
      send_word(OP_CMD, 1'b1, 1'b0);
      send_word(OP_CMD, 1'b0, 1'b1);
      send_word(OP_TICK, 1'b0, 1'b0);
      program_regs(MODE_C, 10'd0, 10'd0, 10'd2);
      send_word(OP_CMD, 1'b0, 1'b0);
      program_regs(MODE_D, 10'd0, 10'd0, 10'd2);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);

      // longest countdown load, still running when the random phases start
      program_regs(MODE_D, WAIT_MAX, WAIT_MAX, WAIT_MAX);
      send_word(OP_CMD, 1'b1, 1'b0);
      repeat (LONG_TICKS)
         send_word(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      // random phases with short waits; sequences may span phase changes
      for (int k = 0; k < PHASES; k++) begin
         program_regs(phase_modes[k], 10'($urandom_range(0, 6)),
                      10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)));
         if (k == 2)
            long_stall = 1'b1;
         if (k == PHASES - 1)
            gaps_on = 1'b0;
         n = RANDOM_WORDS / PHASES;
         repeat (n)
            send_random_word();
      end

      wait_all_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- ir_cut_filter_sequencer.f -----
rtl/icf_pkg.sv
rtl/icf_req_if.sv
rtl/icf_rsp_if.sv
rtl/icf_csr_if.sv
rtl/icf_csr_regs.sv
rtl/icf_core.sv
rtl/ir_cut_filter_sequencer.sv
verif/ir_cut_filter_checker.sv
verif/tb_ir_cut_filter_sequencer.sv
